// File: rtl/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg: shared types and codes of the indexed list engine
// Command opcodes, status codes and the control group of the entry memory.
// ----------------------------------------------------------------------------
package ile_pkg;

    typedef logic [3:0] opcode_t;
    typedef logic [2:0] status_t;

    localparam opcode_t PUSH   = 4'd0;
    localparam opcode_t POP    = 4'd1;
    localparam opcode_t INSERT = 4'd2;
    localparam opcode_t REMOVE = 4'd3;
    localparam opcode_t COUNT  = 4'd4;
    localparam opcode_t GET    = 4'd5;
    localparam opcode_t SET    = 4'd6;
    localparam opcode_t SWAP   = 4'd7;
    localparam opcode_t CLEAR  = 4'd8;

    localparam status_t ST_OK     = 3'd0;
    localparam status_t ST_VALUE  = 3'd1;
    localparam status_t ST_COUNT  = 3'd2;
    localparam status_t ST_BADIDX = 3'd3;
    localparam status_t ST_EMPTY  = 3'd4;
    localparam status_t ST_FULL   = 3'd5;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

// File: rtl/ile_ram.sv
// ----------------------------------------------------------------------------
// ile_ram: entry storage of the indexed list engine
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ile_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 6
) (
    input  logic                 clk,
    input  ile_pkg::mem_ctl_t    ctl,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic [ADDR_W-1:0]    rd_addr,
    output logic [WIDTH-1:0]     rd_data
);
    import ile_pkg::*;

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            entries_reg[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= entries_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/indexed_list_engine_top.sv
// ----------------------------------------------------------------------------
// indexed_list_engine_top: ordered list of words with indexed commands
// One request at a time; the request port stalls until its result is handed to the output.
// Insert and remove shift the entries after the index by moving one entry per
// read and write pair through the memory.
// Reset clears the length, the state and the output valid; the entries are not cleared.
// ----------------------------------------------------------------------------
module indexed_list_engine_top #(
    parameter int CAPACITY  = 64,
    parameter int WORD_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ile_pkg::opcode_t  opcode,
    input  logic [6:0]        first_index,
    input  logic [6:0]        second_index,
    input  logic [31:0]       word_in,
    output logic              out_valid,
    input  logic              out_stall,
    output ile_pkg::status_t  status,
    output logic [31:0]       word_out,
    output logic [6:0]        length_out
);
    import ile_pkg::*;

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (LEN_W > 7) ? LEN_W : 7;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_GRAB    = 4'd2;
    localparam logic [3:0] S_MOVE_RD = 4'd3;
    localparam logic [3:0] S_MOVE_WR = 4'd4;
    localparam logic [3:0] S_SW_A    = 4'd5;
    localparam logic [3:0] S_SW_B    = 4'd6;
    localparam logic [3:0] S_SW_C    = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0]           state_reg, state_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic                 out_valid_reg, out_valid_next;
    opcode_t              op_reg, op_next;
    logic [6:0]           ia_reg, ia_next;
    logic [6:0]           ib_reg, ib_next;
    logic [WORD_BITS-1:0] w_reg, w_next;
    logic [IDX_W-1:0]     cursor_reg, cursor_next;
    logic [IDX_W-1:0]     end_reg, end_next;
    logic                 up_reg, up_next;
    status_t              res_status_reg, res_status_next;
    logic [WORD_BITS-1:0] res_word_reg, res_word_next;
    status_t              status_reg;
    logic [WORD_BITS-1:0] word_out_reg;
    logic [6:0]           length_out_reg;
    logic                 load_out;

    mem_ctl_t             mem_ctl;
    logic [IDX_W-1:0]     wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [IDX_W-1:0]     rd_addr;
    logic [WORD_BITS-1:0] rd_data;

    logic [CMP_W-1:0]     len_ext, ia_ext, ib_ext;
    logic [LEN_W-1:0]     len_dec;
    logic [IDX_W-1:0]     ia_idx, ib_idx, step;
    logic                 full, empty, ia_gt_len, ia_ge_len, ib_ge_len;

    assign len_ext   = CMP_W'(len_reg);
    assign ia_ext    = CMP_W'(ia_reg);
    assign ib_ext    = CMP_W'(ib_reg);
    assign ia_idx    = ia_ext[IDX_W-1:0];
    assign ib_idx    = ib_ext[IDX_W-1:0];
    assign len_dec   = len_reg - LEN_W'(1);
    assign full      = (len_reg == LEN_W'(CAPACITY));
    assign empty     = (len_reg == '0);
    assign ia_gt_len = (ia_ext > len_ext);
    assign ia_ge_len = (ia_ext >= len_ext);
    assign ib_ge_len = (ib_ext >= len_ext);
    assign step      = up_reg ? (cursor_reg + IDX_W'(1)) : (cursor_reg - IDX_W'(1));

    ile_ram #(
        .DEPTH  (CAPACITY),
        .WIDTH  (WORD_BITS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        op_next         = op_reg;
        ia_next         = ia_reg;
        ib_next         = ib_reg;
        w_next          = w_reg;
        cursor_next     = cursor_reg;
        end_next        = end_reg;
        up_next         = up_reg;
        res_status_next = res_status_reg;
        res_word_next   = res_word_reg;
        out_valid_next  = out_valid_reg && out_stall;
        load_out        = 1'b0;
        mem_ctl         = '0;
        wr_addr         = cursor_reg;
        wr_data         = rd_data;
        rd_addr         = step;
        in_stall        = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    ia_next    = first_index;
                    ib_next    = second_index;
                    w_next     = WORD_BITS'(word_in);
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                res_status_next = ST_OK;
                res_word_next   = '0;
                state_next      = S_DONE;
                case (op_reg)
                    PUSH:
                    begin
                        if (full)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_ctl.wr_en = 1'b1;
                            wr_addr       = len_reg[IDX_W-1:0];
                            wr_data       = w_reg;
                            len_next      = len_reg + LEN_W'(1);
                        end
                    end
                    POP:
                    begin
                        if (empty)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            mem_ctl.rd_en   = 1'b1;
                            rd_addr         = len_dec[IDX_W-1:0];
                            len_next        = len_dec;
                            res_status_next = ST_VALUE;
                            state_next      = S_GRAB;
                        end
                    end
                    INSERT:
                    begin
                        if (ia_gt_len)
                        begin
                            res_status_next = ST_BADIDX;
                        end
                        else if (full)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            cursor_next = len_reg[IDX_W-1:0];
                            end_next    = ia_idx;
                            up_next     = 1'b0;
                            state_next  = S_MOVE_RD;
                        end
                    end
                    REMOVE:
                    begin
                        if (ia_ge_len)
                        begin
                            res_status_next = ST_BADIDX;
                        end
                        else
                        begin
                            mem_ctl.rd_en   = 1'b1;
                            rd_addr         = ia_idx;
                            cursor_next     = ia_idx;
                            end_next        = len_dec[IDX_W-1:0];
                            up_next         = 1'b1;
                            res_status_next = ST_VALUE;
                            state_next      = S_GRAB;
                        end
                    end
                    COUNT:
                    begin
                        res_status_next = ST_COUNT;
                    end
                    GET:
                    begin
                        if (ia_ge_len)
                        begin
                            res_status_next = ST_BADIDX;
                        end
                        else
                        begin
                            mem_ctl.rd_en   = 1'b1;
                            rd_addr         = ia_idx;
                            res_status_next = ST_VALUE;
                            state_next      = S_GRAB;
                        end
                    end
                    SET:
                    begin
                        if (ia_ge_len)
                        begin
                            res_status_next = ST_BADIDX;
                        end
                        else
                        begin
                            mem_ctl.wr_en = 1'b1;
                            wr_addr       = ia_idx;
                            wr_data       = w_reg;
                        end
                    end
                    SWAP:
                    begin
                        if (ia_ge_len || ib_ge_len)
                        begin
                            res_status_next = ST_BADIDX;
                        end
                        else
                        begin
                            mem_ctl.rd_en = 1'b1;
                            rd_addr       = ia_idx;
                            state_next    = S_SW_A;
                        end
                    end
                    CLEAR:
                    begin
                        len_next = '0;
                    end
                    default:
                    begin
                        res_status_next = ST_OK;
                    end
                endcase
            end
            S_GRAB:
            begin
                res_word_next = rd_data;
                state_next    = (op_reg == REMOVE) ? S_MOVE_RD : S_DONE;
            end
            S_MOVE_RD:
            begin
                if (cursor_reg == end_reg)
                begin
                    if (up_reg)
                    begin
                        len_next = len_dec;
                    end
                    else
                    begin
                        mem_ctl.wr_en = 1'b1;
                        wr_addr       = cursor_reg;
                        wr_data       = w_reg;
                        len_next      = len_reg + LEN_W'(1);
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = step;
                    state_next    = S_MOVE_WR;
                end
            end
            S_MOVE_WR:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = cursor_reg;
                wr_data       = rd_data;
                cursor_next   = step;
                state_next    = S_MOVE_RD;
            end
            S_SW_A:
            begin
                w_next        = rd_data;
                mem_ctl.rd_en = 1'b1;
                rd_addr       = ib_idx;
                state_next    = S_SW_B;
            end
            S_SW_B:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = ia_idx;
                wr_data       = rd_data;
                state_next    = S_SW_C;
            end
            S_SW_C:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = ib_idx;
                wr_data       = w_reg;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        ia_reg         <= ia_next;
        ib_reg         <= ib_next;
        w_reg          <= w_next;
        cursor_reg     <= cursor_next;
        end_reg        <= end_next;
        up_reg         <= up_next;
        res_status_reg <= res_status_next;
        res_word_reg   <= res_word_next;
        if (load_out)
        begin
            status_reg     <= res_status_reg;
            word_out_reg   <= res_word_reg;
            length_out_reg <= 7'(len_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign word_out   = 32'(word_out_reg);
    assign length_out = length_out_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(CAPACITY))
        else $error("List length is above capacity.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOVE_RD || state_reg == S_MOVE_WR) |-> LEN_W'(cursor_reg) <= len_reg)
        else $error("Move cursor is beyond the list length.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CHECK && state_reg != S_MOVE_RD) |=> $stable(len_reg))
        else $error("List length changed outside a command update.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && out_stall) |=> state_reg == S_DONE)
        else $error("A result left while the previous one was still stalled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> state_reg == S_CHECK)
        else $error("An accepted request did not start its check.");
`endif

endmodule
